// File: src/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg: shared definitions for the ARP cache table
// Table size, field widths, request codes, store write bundle, state codes.
// ----------------------------------------------------------------------------
package arpc_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int IP_W    = 32;
	localparam int MAC_W   = 48;
	localparam int SLOT_W  = 4;
	localparam int REQ_W   = 2;

	localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
	localparam logic [REQ_W-1:0] REQ_FLUSH  = 2'd2;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic             en;
		idx_t             addr;
		logic [IP_W-1:0]  ip;
		logic [MAC_W-1:0] mac;
	} store_wr_t;

	typedef enum logic [2:0] {
		S_IDLE    = 3'b001,
		S_SCAN    = 3'b010,
		S_RESOLVE = 3'b100
	} state_t;

endpackage

// File: src/arpc_store.sv
// ----------------------------------------------------------------------------
// arpc_store: address and MAC storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module arpc_store (
	input  logic                    clk,
	input  arpc_pkg::store_wr_t     wr,
	input  arpc_pkg::idx_t          rd_addr,
	output logic [arpc_pkg::IP_W-1:0]  rd_ip,
	output logic [arpc_pkg::MAC_W-1:0] rd_mac
);
	import arpc_pkg::*;

	logic [IP_W-1:0]  ip_mem  [ENTRIES];
	logic [MAC_W-1:0] mac_mem [ENTRIES];
	logic [IP_W-1:0]  rd_ip_q;
	logic [MAC_W-1:0] rd_mac_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			ip_mem[wr.addr]  <= wr.ip;
			mac_mem[wr.addr] <= wr.mac;
		end
	end

	always_ff @(posedge clk) begin
		rd_ip_q  <= ip_mem[rd_addr];
		rd_mac_q <= mac_mem[rd_addr];
	end

	assign rd_ip  = rd_ip_q;
	assign rd_mac = rd_mac_q;

endmodule

// File: src/arp_cache_table.sv
// ----------------------------------------------------------------------------
// arp_cache_table: IPv4 to MAC cache with round-robin replacement
// Lookup, insert/update and flush over a fixed table, one entry compared
// per cycle by a single address comparator.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  request  req_valid/req_stall  req_type, ip_addr, mac_addr
//  response rsp_valid/rsp_stall  found, mac_out, slot
//
//  Lookup and insert pass through accept, one storage read per entry, a
//  read-latency step and a drain step, then resolve. Flush and unused
//  codes go from accept straight to resolve.
//  Reset clears all valid marks, the victim pointer and the control state.
//  The resolve cycle waits while a previous response is still stalled.
// ----------------------------------------------------------------------------
module arp_cache_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [arpc_pkg::REQ_W-1:0]    req_type,
	input  logic [arpc_pkg::IP_W-1:0]     ip_addr,
	input  logic [arpc_pkg::MAC_W-1:0]    mac_addr,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic                          found,
	output logic [arpc_pkg::MAC_W-1:0]    mac_out,
	output logic [arpc_pkg::SLOT_W-1:0]   slot
);
	import arpc_pkg::*;

	state_t            state_q;
	logic [REQ_W-1:0]  req_q;
	logic [IP_W-1:0]   ip_q;
	logic [MAC_W-1:0]  mac_q;
	logic [ENTRIES-1:0] valid_q;
	idx_t              victim_q;
	logic [CNT_W-1:0]  rd_cnt_q;
	logic              cmp_vld_s1;
	idx_t              cmp_idx_s1;
	logic              hit_q;
	idx_t              hit_idx_q;
	logic [MAC_W-1:0]  hit_mac_q;
	logic              free_q;
	idx_t              free_idx_q;
	logic              rsp_valid_q;
	logic              found_q;
	logic [MAC_W-1:0]  mac_out_q;
	logic [SLOT_W-1:0] slot_q;

	logic [IP_W-1:0]   rd_ip;
	logic [MAC_W-1:0]  rd_mac;
	store_wr_t         wr;
	idx_t              tgt_idx;
	logic              cmp_match;
	logic              cmp_free;
	logic              rsp_free;
	logic              resolve_go;

	arpc_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_cnt_q[IDX_W-1:0]),
		.rd_ip   (rd_ip),
		.rd_mac  (rd_mac)
	);

	assign req_stall  = (state_q != S_IDLE);
	assign rsp_free   = !rsp_valid_q || !rsp_stall;
	assign resolve_go = (state_q == S_RESOLVE) && rsp_free;

	assign cmp_match = cmp_vld_s1 && valid_q[cmp_idx_s1] && (rd_ip == ip_q);
	assign cmp_free  = cmp_vld_s1 && !valid_q[cmp_idx_s1];

	always_comb begin
		tgt_idx = free_q ? free_idx_q : victim_q;
		if (hit_q) begin
			tgt_idx = hit_idx_q;
		end
		wr.en   = resolve_go && (req_q == REQ_INSERT);
		wr.addr = tgt_idx;
		wr.ip   = ip_q;
		wr.mac  = mac_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			victim_q    <= '0;
			rd_cnt_q    <= '0;
			cmp_vld_s1  <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall && !resolve_go) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					rd_cnt_q   <= '0;
					cmp_vld_s1 <= 1'b0;
					hit_q      <= 1'b0;
					free_q     <= 1'b0;
					if (req_valid) begin
						if (req_type == REQ_LOOKUP || req_type == REQ_INSERT) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_RESOLVE;
						end
					end
				end
				S_SCAN: begin
					if (rd_cnt_q < CNT_W'(ENTRIES)) begin
						cmp_vld_s1 <= 1'b1;
						rd_cnt_q   <= rd_cnt_q + 1'b1;
					end else begin
						cmp_vld_s1 <= 1'b0;
						if (!cmp_vld_s1) begin
							state_q <= S_RESOLVE;
						end
					end
					if (cmp_match && !hit_q) begin
						hit_q <= 1'b1;
					end
					if (cmp_free && !free_q) begin
						free_q <= 1'b1;
					end
				end
				S_RESOLVE: begin
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (req_q == REQ_INSERT) begin
							valid_q[tgt_idx] <= 1'b1;
							if (!hit_q && !free_q) begin
								victim_q <= (victim_q == IDX_W'(ENTRIES - 1)) ?
									'0 : victim_q + 1'b1;
							end
						end else if (req_q == REQ_FLUSH) begin
							valid_q  <= '0;
							victim_q <= '0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			req_q <= req_type;
			ip_q  <= ip_addr;
			mac_q <= mac_addr;
		end
		cmp_idx_s1 <= rd_cnt_q[IDX_W-1:0];
		if (state_q == S_SCAN && cmp_match && !hit_q) begin
			hit_idx_q <= cmp_idx_s1;
			hit_mac_q <= rd_mac;
		end
		if (state_q == S_SCAN && cmp_free && !free_q) begin
			free_idx_q <= cmp_idx_s1;
		end
		if (resolve_go) begin
			case (req_q)
				REQ_LOOKUP: begin
					found_q   <= hit_q;
					mac_out_q <= hit_q ? hit_mac_q : '0;
					slot_q    <= hit_q ? SLOT_W'(hit_idx_q) : '0;
				end
				REQ_INSERT: begin
					found_q   <= hit_q;
					mac_out_q <= '0;
					slot_q    <= SLOT_W'(tgt_idx);
				end
				default: begin
					found_q   <= 1'b0;
					mac_out_q <= '0;
					slot_q    <= '0;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign found     = found_q;
	assign mac_out   = mac_out_q;
	assign slot      = slot_q;

	// a stored hit always points at a valid entry
	a_hit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESOLVE && hit_q) |-> valid_q[hit_idx_q])
		else $error("hit index not valid");

	// an insert leaves its target entry valid
	a_insert_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |=> valid_q[$past(wr.addr)])
		else $error("inserted entry not valid");

	// flush empties the table and resets the victim pointer
	a_flush_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(resolve_go && req_q == REQ_FLUSH) |=> (valid_q == '0 && victim_q == '0))
		else $error("flush did not clear table");

	// a response only appears out of the resolve cycle
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_RESOLVE))
		else $error("response without resolve");

endmodule

// File: tb/sv/tb_arp_cache_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arp_cache_table: self-checking bench for the ARP cache table
// A short directed table, then random lookup, insert, flush and unused-code
// traffic over a small, changing address pool so that the table fills and
// evicts. Every response is checked field by field against a typed row or a
// local model of the cache. Random request gaps and response stalls apply.
// ----------------------------------------------------------------------------
module tb_arp_cache_table;
	import arpc_pkg::*;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int N_RANDOM    = 2000;
	localparam int IDLE_LIMIT  = 5000;
	localparam int TAIL_CYCLES = 2 * (ENTRIES + 3) + 10;
	localparam int POOL_MAX    = 32;
	localparam int MAX_SHOWN   = 10;
	localparam int N_DIR       = 20;

	typedef struct {
		logic              found;
		logic [MAC_W-1:0]  mac;
		logic [SLOT_W-1:0] slot;
	} arp_rsp_t;

	typedef struct {
		logic [REQ_W-1:0] kind;
		logic [IP_W-1:0]  ip;
		logic [MAC_W-1:0] mac;
		bit               typed;
		arp_rsp_t         rsp;
	} dir_row_t;

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_stall;
	logic [REQ_W-1:0]  req_type;
	logic [IP_W-1:0]   ip_addr;
	logic [MAC_W-1:0]  mac_addr;
	logic              rsp_valid;
	logic              rsp_stall;
	logic              found;
	logic [MAC_W-1:0]  mac_out;
	logic [SLOT_W-1:0] slot;

	arp_cache_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.ip_addr   (ip_addr),
		.mac_addr  (mac_addr),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.found     (found),
		.mac_out   (mac_out),
		.slot      (slot)
	);

	// cache model
	logic             tab_valid [ENTRIES];
	logic [IP_W-1:0]  tab_ip    [ENTRIES];
	logic [MAC_W-1:0] tab_mac   [ENTRIES];
	int               victim;

	arp_rsp_t         pending_rsp [$];
	logic [IP_W-1:0]  ip_pool [POOL_MAX];
	int               pool_size;
	bit               quiet;
	int               n_errors;
	int               n_checked;
	int               n_requests;
	int               n_hits;
	int               n_evicts;
	int               n_flushes;
	int               idle_cycles;

	// typed rows: miss after reset, first fills, extremes, update, unused code, flush
	dir_row_t dir_tab [N_DIR] = '{
		'{REQ_LOOKUP, 32'h0,        48'h0,             1'b1, '{1'b0, 48'h0, 4'd0}},
		'{REQ_LOOKUP, 32'hFFFFFFFF, 48'hFFFF_FFFF_FFFF, 1'b1, '{1'b0, 48'h0, 4'd0}},
		'{REQ_INSERT, 32'h0,        48'h0,             1'b1, '{1'b0, 48'h0, 4'd0}},
		'{REQ_INSERT, 32'hFFFFFFFF, 48'hFFFF_FFFF_FFFF, 1'b1, '{1'b0, 48'h0, 4'd1}},
		'{REQ_LOOKUP, 32'hFFFFFFFF, 48'h0,             1'b1,
			'{1'b1, 48'hFFFF_FFFF_FFFF, 4'd1}},
		'{REQ_LOOKUP, 32'h0,        48'hFFFF_FFFF_FFFF, 1'b1, '{1'b1, 48'h0, 4'd0}},
		'{REQ_INSERT, 32'h0,        48'hFFFF_FFFF_FFFF, 1'b1, '{1'b1, 48'h0, 4'd0}},
		'{REQ_LOOKUP, 32'h0,        48'h0,             1'b1,
			'{1'b1, 48'hFFFF_FFFF_FFFF, 4'd0}},
		'{REQ_UNUSED, 32'h12345678, 48'hFFFF_FFFF_FFFF, 1'b1, '{1'b0, 48'h0, 4'd0}},
		'{REQ_LOOKUP, 32'h12345678, 48'h0,             1'b1, '{1'b0, 48'h0, 4'd0}},
		'{REQ_INSERT, 32'hAAAAAAAA, 48'hAAAA_AAAA_AAAA, 1'b0, '{1'b0, 48'h0, 4'd0}},
		'{REQ_INSERT, 32'h55555555, 48'h5555_5555_5555, 1'b0, '{1'b0, 48'h0, 4'd0}},
		'{REQ_LOOKUP, 32'hAAAAAAAA, 48'h0,             1'b0, '{1'b0, 48'h0, 4'd0}},
		'{REQ_FLUSH,  32'hAAAAAAAA, 48'hFFFF_FFFF_FFFF, 1'b1, '{1'b0, 48'h0, 4'd0}},
		'{REQ_LOOKUP, 32'hFFFFFFFF, 48'h0,             1'b1, '{1'b0, 48'h0, 4'd0}},
		'{REQ_INSERT, 32'h55555555, 48'h0123_4567_89AB, 1'b1, '{1'b0, 48'h0, 4'd0}},
		'{REQ_LOOKUP, 32'h55555555, 48'h0,             1'b0, '{1'b0, 48'h0, 4'd0}},
		'{REQ_LOOKUP, 32'hAAAAAAAA, 48'h0,             1'b1, '{1'b0, 48'h0, 4'd0}},
		'{REQ_FLUSH,  32'hFFFFFFFF, 48'h0,             1'b1, '{1'b0, 48'h0, 4'd0}},
		'{REQ_FLUSH,  32'h0,        48'h0,             1'b1, '{1'b0, 48'h0, 4'd0}}
	};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic arp_rsp_t cache_predict(input logic [REQ_W-1:0] kind,
			input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
		arp_rsp_t r;
		int hit;
		int idx;
		int i;
		r = '{1'b0, '0, '0};
		hit = -1;
		idx = -1;
		for (i = 0; i < ENTRIES; i++) begin
			if (hit < 0 && tab_valid[i] && tab_ip[i] == ip) hit = i;
			if (idx < 0 && !tab_valid[i]) idx = i;
		end
		case (kind)
			REQ_LOOKUP: begin
				if (hit >= 0) begin
					r.found = 1'b1;
					r.mac   = tab_mac[hit];
					r.slot  = SLOT_W'(hit);
					n_hits++;
				end
			end
			REQ_INSERT: begin
				if (hit >= 0) begin
					r.found      = 1'b1;
					tab_mac[hit] = mac;
					r.slot       = SLOT_W'(hit);
				end else begin
					if (idx < 0) begin
						idx    = victim;
						victim = (victim + 1) % ENTRIES;
						n_evicts++;
					end
					tab_valid[idx] = 1'b1;
					tab_ip[idx]    = ip;
					tab_mac[idx]   = mac;
					r.slot         = SLOT_W'(idx);
				end
			end
			REQ_FLUSH: begin
				for (i = 0; i < ENTRIES; i++) tab_valid[i] = 1'b0;
				victim = 0;
				n_flushes++;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 20);
		return $urandom_range(30, 120);
	endfunction

	function automatic void refill_pool();
		int i;
		pool_size = $urandom_range(4, POOL_MAX);
		for (i = 0; i < POOL_MAX; i++) ip_pool[i] = $urandom;
		ip_pool[0] = '0;
		ip_pool[1] = '1;
	endfunction

	task automatic flag_error(input string msg);
		n_errors++;
		if (n_errors <= MAX_SHOWN) $display("ERROR at %0t: %s", $time, msg);
	endtask

	task automatic send_req(input logic [REQ_W-1:0] kind, input logic [IP_W-1:0] ip,
			input logic [MAC_W-1:0] mac, input bit typed, input arp_rsp_t typed_rsp);
		int gap;
		arp_rsp_t want;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_type  <= kind;
		ip_addr   <= ip;
		mac_addr  <= mac;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		want = cache_predict(kind, ip, mac);
		pending_rsp.push_back(typed ? typed_rsp : want);
		n_requests++;
	endtask

	// response stall pattern
	initial begin
		int n;
		rsp_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			n = pick_gap();
			if (n > 0) begin
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin : rsp_check
		arp_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				flag_error($sformatf("unexpected transaction found=%0b mac=%h slot=%0d",
					found, mac_out, slot));
			end else begin
				want = pending_rsp.pop_front();
				n_checked++;
				if (found !== want.found)
					flag_error($sformatf("rsp %0d found: exp %0b got %0b",
						n_checked, want.found, found));
				if (mac_out !== want.mac)
					flag_error($sformatf("rsp %0d mac_out: exp %h got %h",
						n_checked, want.mac, mac_out));
				if (slot !== want.slot)
					flag_error($sformatf("rsp %0d slot: exp %0d got %0d",
						n_checked, want.slot, slot));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", idle_cycles);
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [REQ_W-1:0] kind;
		logic [IP_W-1:0]  ip;
		logic [MAC_W-1:0] mac;
		arp_rsp_t         no_rsp;
		int               r;
		int               n;
		int               i;
		arst_n      <= 1'b0;
		req_valid   <= 1'b0;
		req_type    <= REQ_LOOKUP;
		ip_addr     <= '0;
		mac_addr    <= '0;
		no_rsp = '{1'b0, '0, '0};
		for (i = 0; i < ENTRIES; i++) begin
			tab_valid[i] = 1'b0;
			tab_ip[i]    = '0;
			tab_mac[i]   = '0;
		end
		victim = 0;
		quiet  = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < N_DIR; i++)
			send_req(dir_tab[i].kind, dir_tab[i].ip, dir_tab[i].mac, dir_tab[i].typed,
				dir_tab[i].rsp);

		// mostly pooled addresses so inserts refill, hit and evict
		refill_pool();
		for (n = 0; n < N_RANDOM; n++) begin
			if ($urandom_range(0, 149) == 0) quiet = !quiet;
			r = $urandom_range(0, 199);
			if (r < 88)       kind = REQ_LOOKUP;
			else if (r < 194) kind = REQ_INSERT;
			else if (r < 197) kind = REQ_FLUSH;
			else              kind = REQ_UNUSED;
			if ($urandom_range(0, 99) < 85) ip = ip_pool[$urandom_range(0, pool_size - 1)];
			else                            ip = $urandom;
			r = $urandom_range(0, 19);
			if (r == 0)      mac = '0;
			else if (r == 1) mac = '1;
			else             mac = MAC_W'({$urandom, $urandom});
			send_req(kind, ip, mac, 1'b0, no_rsp);
			if (kind == REQ_FLUSH) refill_pool();
		end
		req_valid <= 1'b0;

		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d requests: %0d lookup hits, %0d evictions, %0d flushes.",
			n_requests, n_hits, n_evicts, n_flushes);
		$display("Checked %0d responses, %0d mismatches.", n_checked, n_errors);
		if (n_errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
